>>> rtl/stcr_pkg.sv
// ----------------------------------------------------------------------------
// stcr_pkg: shared types and constants for the scrolling text column renderer
// Request kinds, character codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package stcr_pkg;
    localparam int PANEL_WIDTH = 120;
    localparam int MAX_CHARS   = 64;
    localparam int GLYPH_COLS  = 8;
    localparam int GLYPH_GAP   = 1;
    localparam int WIDTH_MAX   = 1023;

    localparam int PW_W  = $clog2(PANEL_WIDTH);       // column address
    localparam int MC_W  = $clog2(MAX_CHARS);         // text address
    localparam int CNT_W = $clog2(MAX_CHARS + 1);     // char count
    localparam int GC_W  = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
    localparam int GW_W  = $clog2(GLYPH_COLS + 1);    // glyph width
    localparam int GA_W  = 8 + GC_W;                  // font column address

    localparam logic [2:0] KIND_WIDTH  = 3'd0;
    localparam logic [2:0] KIND_COLUMN = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP_RD,   // read pending/message char for compare
        ST_CMP_CHK,
        ST_COPY_RD,  // copy pending -> message, measure widths
        ST_COPY_WR,
        ST_COPY_W2,
        ST_CLEAR,    // zero the column buffer
        ST_RND_RD,   // fetch message char
        ST_RND_W,    // fetch glyph width
        ST_RND_COL,  // write glyph columns
        ST_READ,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

>>> rtl/stcr_font.sv
// ----------------------------------------------------------------------------
// stcr_font: glyph width table and glyph column memory
// Width table has per-entry valid bits; column memory is plain storage.
// ----------------------------------------------------------------------------
`default_nettype none
module stcr_font (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wwr_en,
    input  wire logic [7:0]                    wwr_glyph,
    input  wire logic [stcr_pkg::GW_W-1:0]     wwr_data,
    input  wire logic [7:0]                    wrd_glyph,
    output      logic [stcr_pkg::GW_W-1:0]     wrd_data,
    input  wire logic                          cwr_en,
    input  wire logic [stcr_pkg::GA_W-1:0]     cwr_addr,
    input  wire logic [7:0]                    cwr_data,
    input  wire logic [stcr_pkg::GA_W-1:0]     crd_addr,
    output      logic [7:0]                    crd_data
);
    logic [stcr_pkg::GW_W-1:0] width_mem [256];
    logic [255:0]              wvalid_reg;
    logic [7:0]                col_mem [2**stcr_pkg::GA_W];
    logic [stcr_pkg::GW_W-1:0] wq_reg;
    logic                      wq_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg   <= '0;
            wq_valid_reg <= 1'b0;
        end
        else
        begin
            if (wwr_en)
            begin
                wvalid_reg[wwr_glyph] <= 1'b1;
            end
            wq_valid_reg <= wvalid_reg[wrd_glyph];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wwr_en)
        begin
            width_mem[wwr_glyph] <= wwr_data;
        end
        wq_reg <= width_mem[wrd_glyph];
        if (cwr_en)
        begin
            col_mem[cwr_addr] <= cwr_data;
        end
        crd_data <= col_mem[crd_addr];
    end

    assign wrd_data = wq_valid_reg ? wq_reg : '0;
endmodule
`default_nettype wire

>>> rtl/stcr_text.sv
// ----------------------------------------------------------------------------
// stcr_text: pending line and message text memories
// ----------------------------------------------------------------------------
`default_nettype none
module stcr_text (
    input  wire logic                      clk,
    input  wire logic                      pwr_en,
    input  wire logic [stcr_pkg::MC_W-1:0] pwr_addr,
    input  wire logic [7:0]                pwr_data,
    input  wire logic [stcr_pkg::MC_W-1:0] prd_addr,
    output      logic [7:0]                prd_data,
    input  wire logic                      mwr_en,
    input  wire logic [stcr_pkg::MC_W-1:0] mwr_addr,
    input  wire logic [7:0]                mwr_data,
    input  wire logic [stcr_pkg::MC_W-1:0] mrd_addr,
    output      logic [7:0]                mrd_data
);
    logic [7:0] pend_mem [stcr_pkg::MAX_CHARS];
    logic [7:0] msg_mem  [stcr_pkg::MAX_CHARS];

    always_ff @(posedge clk)
    begin
        if (pwr_en)
        begin
            pend_mem[pwr_addr] <= pwr_data;
        end
        prd_data <= pend_mem[prd_addr];
        if (mwr_en)
        begin
            msg_mem[mwr_addr] <= mwr_data;
        end
        mrd_data <= msg_mem[mrd_addr];
    end
endmodule
`default_nettype wire

>>> rtl/stcr_colbuf.sv
// ----------------------------------------------------------------------------
// stcr_colbuf: column buffer memory, one pixel column per entry
// Reset value zero via per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module stcr_colbuf (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [stcr_pkg::PW_W-1:0] wr_addr,
    input  wire logic [7:0]                wr_data,
    input  wire logic [stcr_pkg::PW_W-1:0] rd_addr,
    output      logic [7:0]                rd_data
);
    logic [7:0]                       mem [stcr_pkg::PANEL_WIDTH];
    logic [stcr_pkg::PANEL_WIDTH-1:0] valid_reg;
    logic [7:0]                       q_reg;
    logic                             qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            qv_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    assign rd_data = qv_reg ? q_reg : '0;
endmodule
`default_nettype wire

>>> rtl/scrolling_text_column_renderer.sv
// ----------------------------------------------------------------------------
// scrolling_text_column_renderer: LED marquee column renderer
// Font, text and column buffer live in synchronous memories; a sequencer
// reads, modifies and writes them back.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  in      | in_valid, in_stall, kind, glyph,            | request in
//          | glyph_column, data, column                  |
//  out     | out_valid, out_stall, column_bits           | result out
//
//  A column read passes a memory read, then the result register. A newline
//  walks the line: it compares each pending char with the message and,
//  on a mismatch or a length change, copies pending to message and sums
//  widths. A render tick clears PANEL_WIDTH entries and then fetches each
//  glyph and its width and writes its columns.
//  Reset empties both lines and zeroes the widths and column buffer at once.
//  in_stall is high whenever the sequencer is busy or a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module scrolling_text_column_renderer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] glyph,
    input  wire logic [2:0] glyph_column,
    input  wire logic [7:0] data,
    input  wire logic [6:0] column,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [7:0] column_bits
);
    localparam int PW    = stcr_pkg::PANEL_WIDTH;
    localparam int MC_W  = stcr_pkg::MC_W;
    localparam int CNT_W = stcr_pkg::CNT_W;
    localparam int GW_W  = stcr_pkg::GW_W;
    localparam int GC_W  = stcr_pkg::GC_W;
    localparam int PW_W  = stcr_pkg::PW_W;

    stcr_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] pcount_reg, pcount_next;
    logic [CNT_W-1:0] mcount_reg, mcount_next;
    logic [9:0]       tpw_reg, tpw_next;
    logic [2:0]       phase_reg, phase_next;
    logic signed [10:0] offs_reg, offs_next;
    logic [CNT_W-1:0] idx_reg, idx_next;     // char index
    logic [10:0]      sum_reg, sum_next;     // width accumulator
    logic signed [11:0] pos_reg, pos_next;   // render position
    logic [GW_W-1:0]  x_reg, x_next;         // column within glyph
    logic [GW_W-1:0]  gw_reg, gw_next;
    logic [7:0]       g_reg, g_next;
    logic [7:0]       res_reg, res_next;
    logic             ov_reg, ov_next;
    logic [PW_W-1:0]  clr_reg, clr_next;
    logic             rend_reg, rend_next;   // render after clearing

    logic accept;
    assign accept = in_valid && !in_stall;

    // memory port wires
    logic                wwr_en;
    logic [GW_W-1:0]     wwr_data;
    logic [7:0]          wrd_glyph;
    logic [GW_W-1:0]     wrd_data;
    logic                cwr_en;
    logic [stcr_pkg::GA_W-1:0] crd_addr;
    logic [7:0]          crd_data;
    logic                pwr_en;
    logic [MC_W-1:0]     prd_addr, mrd_addr, mwr_addr;
    logic [7:0]          prd_data, mrd_data;
    logic                mwr_en;
    logic                cb_wr_en;
    logic [PW_W-1:0]     cb_wr_addr, cb_rd_addr;
    logic [7:0]          cb_wr_data, cb_rd_data;

    // column address check, held with the read request
    logic column_reg_ok;
    logic [6:0] col_reg;

    assign wwr_en   = accept && kind == stcr_pkg::KIND_WIDTH;
    assign wwr_data = (data > 8'(stcr_pkg::GLYPH_COLS)) ?
                      GW_W'(stcr_pkg::GLYPH_COLS) : GW_W'(data);
    assign cwr_en   = accept && kind == stcr_pkg::KIND_COLUMN &&
                      {1'b0, glyph_column} < 4'(stcr_pkg::GLYPH_COLS);

    stcr_font u_font (
        .clk       (clk),
        .rst_n     (rst_n),
        .wwr_en    (wwr_en),
        .wwr_glyph (glyph),
        .wwr_data  (wwr_data),
        .wrd_glyph (wrd_glyph),
        .wrd_data  (wrd_data),
        .cwr_en    (cwr_en),
        .cwr_addr  ({glyph, GC_W'(glyph_column)}),
        .cwr_data  (data),
        .crd_addr  (crd_addr),
        .crd_data  (crd_data)
    );

    // a plain character is appended on acceptance while the line has room
    assign pwr_en = accept && kind == stcr_pkg::KIND_CHAR &&
                    data != stcr_pkg::CH_BACKSPACE && data != stcr_pkg::CH_NEWLINE &&
                    data != stcr_pkg::CH_RETURN &&
                    pcount_reg < CNT_W'(stcr_pkg::MAX_CHARS);

    stcr_text u_text (
        .clk      (clk),
        .pwr_en   (pwr_en),
        .pwr_addr (pcount_reg[MC_W-1:0]),
        .pwr_data (data),
        .prd_addr (prd_addr),
        .prd_data (prd_data),
        .mwr_en   (mwr_en),
        .mwr_addr (mwr_addr),
        .mwr_data (prd_data),
        .mrd_addr (mrd_addr),
        .mrd_data (mrd_data)
    );

    stcr_colbuf u_colbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cb_wr_en),
        .wr_addr (cb_wr_addr),
        .wr_data (cb_wr_data),
        .rd_addr (cb_rd_addr),
        .rd_data (cb_rd_data)
    );

    assign in_stall  = (state_reg != stcr_pkg::ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign column_bits = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stcr_pkg::ST_IDLE;
            pcount_reg <= '0;
            mcount_reg <= '0;
            tpw_reg    <= '0;
            phase_reg  <= '0;
            offs_reg   <= 11'(PW);
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pcount_reg <= pcount_next;
            mcount_reg <= mcount_next;
            tpw_reg    <= tpw_next;
            phase_reg  <= phase_next;
            offs_reg   <= offs_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        pos_reg  <= pos_next;
        x_reg    <= x_next;
        gw_reg   <= gw_next;
        g_reg    <= g_next;
        res_reg  <= res_next;
        clr_reg  <= clr_next;
        rend_reg <= rend_next;
    end

    logic [10:0] sum_w;
    logic [9:0]  meas;
    logic [2:0]  ph1;
    always_comb
    begin
        state_next  = state_reg;
        pcount_next = pcount_reg;
        mcount_next = mcount_reg;
        tpw_next    = tpw_reg;
        phase_next  = phase_reg;
        offs_next   = offs_reg;
        ov_next     = ov_reg && out_stall;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        x_next      = x_reg;
        gw_next     = gw_reg;
        g_next      = g_reg;
        res_next    = res_reg;
        clr_next    = clr_reg;
        rend_next   = rend_reg;
        wrd_glyph   = mrd_data;
        crd_addr    = {g_reg, x_reg[GC_W-1:0]};
        prd_addr    = idx_reg[MC_W-1:0];
        mrd_addr    = idx_reg[MC_W-1:0];
        mwr_en      = 1'b0;
        mwr_addr    = idx_reg[MC_W-1:0];
        cb_wr_en    = 1'b0;
        cb_wr_addr  = clr_reg;
        cb_wr_data  = '0;
        cb_rd_addr  = column[PW_W-1:0];
        sum_w       = '0;
        meas        = '0;
        ph1         = phase_reg + 3'd1;

        unique case (state_reg)
            stcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        stcr_pkg::KIND_CHAR:
                        begin
                            if (pwr_en)
                            begin
                                pcount_next = pcount_reg + 1'b1;
                            end
                            else if (data == stcr_pkg::CH_BACKSPACE)
                            begin
                                if (pcount_reg != '0)
                                begin
                                    pcount_next = pcount_reg - 1'b1;
                                end
                            end
                            else if (data == stcr_pkg::CH_NEWLINE && pcount_reg != '0)
                            begin
                                idx_next = '0;
                                if (pcount_reg == mcount_reg)
                                begin
                                    state_next = stcr_pkg::ST_CMP_RD;
                                end
                                else
                                begin
                                    sum_next   = '0;
                                    state_next = stcr_pkg::ST_COPY_RD;
                                end
                            end
                        end
                        stcr_pkg::KIND_TICK:
                        begin
                            if (ph1 == 3'd6)
                            begin
                                phase_next = ph1;
                                if (tpw_reg > 10'(PW))
                                begin
                                    clr_next   = '0;
                                    rend_next  = 1'b0;
                                    state_next = stcr_pkg::ST_CLEAR;
                                end
                            end
                            else if (ph1 == 3'd0)
                            begin
                                phase_next = '0;
                                clr_next   = '0;
                                rend_next  = 1'b1;
                                idx_next   = '0;
                                state_next = stcr_pkg::ST_CLEAR;
                                if (tpw_reg > 10'(PW))
                                begin
                                    pos_next  = 12'(offs_reg - 11'sd1);
                                    offs_next = offs_reg - 11'sd1;
                                    if (offs_reg - 11'sd1 == -$signed({1'b0, tpw_reg}))
                                    begin
                                        offs_next = 11'(PW);
                                    end
                                end
                                else
                                begin
                                    pos_next = 12'((11'(PW) - {1'b0, tpw_reg}) >> 1);
                                end
                            end
                            else
                            begin
                                phase_next = ph1;
                            end
                        end
                        stcr_pkg::KIND_READ:
                        begin
                            state_next = stcr_pkg::ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            stcr_pkg::ST_READ:
            begin
                // hold the captured column on the read port
                cb_rd_addr = col_reg[PW_W-1:0];
                state_next = stcr_pkg::ST_OUT;
            end
            stcr_pkg::ST_OUT:
            begin
                res_next   = (column_reg_ok) ? cb_rd_data : '0;
                ov_next    = 1'b1;
                state_next = stcr_pkg::ST_IDLE;
            end
            stcr_pkg::ST_CMP_RD:
            begin
                state_next = stcr_pkg::ST_CMP_CHK;
            end
            stcr_pkg::ST_CMP_CHK:
            begin
                if (prd_data != mrd_data)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = stcr_pkg::ST_COPY_RD;
                end
                else if (idx_reg + 1'b1 == pcount_reg)
                begin
                    pcount_next = '0;
                    state_next  = stcr_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = stcr_pkg::ST_CMP_RD;
                end
            end
            stcr_pkg::ST_COPY_RD:
            begin
                state_next = stcr_pkg::ST_COPY_WR;
            end
            stcr_pkg::ST_COPY_WR:
            begin
                // width lookup of the char being copied
                wrd_glyph  = prd_data;
                mwr_en     = 1'b1;
                state_next = stcr_pkg::ST_COPY_W2;
            end
            stcr_pkg::ST_COPY_W2:
            begin
                // width read of message char just written is now valid
                prd_addr = idx_reg[MC_W-1:0];
                if (wrd_data != '0)
                begin
                    sum_w = sum_reg + 11'(wrd_data) + 11'(stcr_pkg::GLYPH_GAP);
                    sum_next = (sum_w > 11'(stcr_pkg::WIDTH_MAX + 1)) ?
                               11'(stcr_pkg::WIDTH_MAX + 1) : sum_w;
                end
                if (idx_reg + 1'b1 == pcount_reg)
                begin
                    sum_w = (wrd_data != '0) ? (sum_reg + 11'(wrd_data) + 11'd1) : sum_reg;
                    meas  = (sum_w == '0) ? '0 :
                            ((sum_w - 11'd1 > 11'(stcr_pkg::WIDTH_MAX)) ?
                             10'(stcr_pkg::WIDTH_MAX) : 10'(sum_w - 11'd1));
                    tpw_next    = meas;
                    mcount_next = pcount_reg;
                    pcount_next = '0;
                    phase_next  = '0;
                    offs_next   = 11'(PW);
                    state_next  = stcr_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = stcr_pkg::ST_COPY_RD;
                end
            end
            stcr_pkg::ST_CLEAR:
            begin
                cb_wr_en   = 1'b1;
                cb_wr_addr = clr_reg;
                cb_wr_data = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == PW_W'(PW - 1))
                begin
                    state_next = (rend_reg && mcount_reg != '0) ?
                                 stcr_pkg::ST_RND_RD : stcr_pkg::ST_IDLE;
                end
            end
            stcr_pkg::ST_RND_RD:
            begin
                // message char read issued at idx_reg
                state_next = stcr_pkg::ST_RND_W;
            end
            stcr_pkg::ST_RND_W:
            begin
                // width read issued with glyph from memory
                g_next     = mrd_data;
                x_next     = '0;
                state_next = stcr_pkg::ST_RND_COL;
                gw_next    = '0;
                rend_next  = 1'b0;   // width not yet sampled
            end
            stcr_pkg::ST_RND_COL:
            begin
                if (!rend_reg)
                begin
                    // first cycle: width data valid, column 0 read in flight
                    gw_next   = wrd_data;
                    rend_next = 1'b1;
                    if (wrd_data == '0)
                    begin
                        pos_next = pos_reg + 12'sd1;
                        idx_next = idx_reg + 1'b1;
                        rend_next = 1'b1;
                        state_next = (idx_reg + 1'b1 == mcount_reg || pos_reg + 12'sd1 >= 12'(PW))
                                     ? stcr_pkg::ST_IDLE : stcr_pkg::ST_RND_RD;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;  // prefetch next column
                    end
                end
                else if (pos_reg >= 12'(PW))
                begin
                    state_next = stcr_pkg::ST_IDLE;
                end
                else
                begin
                    crd_addr = {g_reg, x_reg[GC_W-1:0]};
                    if (pos_reg >= 0)
                    begin
                        cb_wr_en   = 1'b1;
                        cb_wr_addr = PW_W'(pos_reg);
                        cb_wr_data = crd_data;
                    end
                    pos_next = pos_reg + 12'sd1;
                    x_next   = x_reg + 1'b1;
                    if (x_reg == gw_reg)
                    begin
                        // last column of this glyph written; add gap
                        pos_next = pos_reg + 12'sd1 + 12'(stcr_pkg::GLYPH_GAP);
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == mcount_reg ||
                            pos_reg + 12'sd2 >= 12'(PW))
                        begin
                            state_next = stcr_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = stcr_pkg::ST_RND_RD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = stcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= column;
        end
    end
    assign column_reg_ok = col_reg < 7'(PW);
endmodule
`default_nettype wire
